// ===== rtl/sbb_pkg.sv =====
// Shared constants and register codes for the sub-pixel block binning engine.
// Used by sbb_ram users and the subpixel_block_binning top level; no dependencies.
`default_nettype none

package sbb_pkg;

  // Sizing limits
  localparam int MAX_PIXEL_COLUMNS = 1024;
  localparam int MAX_BIN_FACTOR    = 16;
  localparam int FLUX_BITS         = 24;

  // Fixed field widths
  localparam int SUM_W      = 32;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int FACT_REG_W = 5;
  localparam int COLS_REG_W = 11;
  localparam int ROWS_REG_W = 13;

  localparam int COLS_LIMIT = 1024;
  localparam int ROWS_LIMIT = 4096;

  // Effective upper bounds of the registers
  localparam int FACTOR_HI = (MAX_BIN_FACTOR < 31) ? MAX_BIN_FACTOR : 31;
  localparam int COLS_HI   = (MAX_PIXEL_COLUMNS < COLS_LIMIT) ? MAX_PIXEL_COLUMNS : COLS_LIMIT;

  // Sub-pixel counter and line buffer sizing
  localparam int SUB_W      = (FACTOR_HI > 1) ? $clog2(FACTOR_HI) : 1;
  localparam int LINE_DEPTH = COLS_HI;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // APB-style register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 2;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_BIN_FACTOR    = 2'd0;
  localparam reg_idx_t REG_PIXEL_COLUMNS = 2'd1;
  localparam reg_idx_t REG_PIXEL_ROWS    = 2'd2;

  localparam logic [FACT_REG_W-1:0] RST_BIN_FACTOR    = 5'd4;
  localparam logic [COLS_REG_W-1:0] RST_PIXEL_COLUMNS = 11'd1024;
  localparam logic [ROWS_REG_W-1:0] RST_PIXEL_ROWS    = 13'd1024;

endpackage

`default_nettype wire

// ===== rtl/sbb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; sized by WIDTH and DEPTH.
`default_nettype none

module sbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/subpixel_block_binning.sv =====
// Top level of the sub-pixel block binning engine: counters, register port,
// read-modify-write of the column partial-sum line and output buffering.
// Depends on sbb_pkg and sbb_ram.
`default_nettype none

// Pipeline: an accepted word reads the partial-sum line and is held in s1_r;
// then it is added and written back, the last sub-pixel of a square moving its
// pixel word into the output buffer. Throughput: one sub-pixel word per clock
// while in_stall is low, set by the separate read and write ports of the line.
// Reset (rst_n low, synchronous): counters, registers and handshake state go
// to reset values; the partial-sum line is not cleared (first sub-row writes).

module subpixel_block_binning (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // sub-pixel input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sbb_pkg::FLUX_BITS-1:0]      in_flux,
  input  wire logic                               in_frame_start,
  // pixel output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [sbb_pkg::SUM_W-1:0]          out_pixel_sum,
  output logic      [sbb_pkg::ROW_W-1:0]          out_pixel_row,
  output logic      [sbb_pkg::COL_W-1:0]          out_pixel_column,
  output logic                                    out_frame_end,
  // register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sbb_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [sbb_pkg::DATA_W-1:0]         pwdata,
  output logic      [sbb_pkg::DATA_W-1:0]         prdata,
  output logic                                    pready
);

  localparam int FW  = sbb_pkg::FACT_REG_W;
  localparam int CW  = sbb_pkg::COLS_REG_W;
  localparam int RW  = sbb_pkg::ROWS_REG_W;
  localparam int SW  = sbb_pkg::SUB_W;
  localparam int PCW = sbb_pkg::COL_W;
  localparam int PRW = sbb_pkg::ROW_W;
  localparam int AW  = sbb_pkg::LINE_AW;
  localparam int DW  = sbb_pkg::SUM_W;

  // Word in flight between RAM read and write-back
  typedef struct packed {
    logic [AW-1:0]                 addr;
    logic [sbb_pkg::FLUX_BITS-1:0] flux;
    logic                          first;   // first sub-pixel of the square
    logic                          emit;    // last sub-pixel of the square
    logic [PRW-1:0]                row;
    logic [PCW-1:0]                col;
    logic                          last;    // last pixel of the frame
  } rmw_t;

  // Pixel word as held in the output buffer
  typedef struct packed {
    logic [DW-1:0]  sum;
    logic [PRW-1:0] row;
    logic [PCW-1:0] col;
    logic           last;
  } pix_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FW-1:0] bin_factor_r, bin_factor_nxt;
  logic [CW-1:0] pixel_columns_r, pixel_columns_nxt;
  logic [RW-1:0] pixel_rows_r, pixel_rows_nxt;

  logic                  cfg_wr;
  logic                  cfg_hit;   // write to an existing register
  sbb_pkg::reg_idx_t     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[sbb_pkg::IDX_W+1:2];

  always_comb begin
    bin_factor_nxt    = bin_factor_r;
    pixel_columns_nxt = pixel_columns_r;
    pixel_rows_nxt    = pixel_rows_r;
    cfg_hit           = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_idx)
        sbb_pkg::REG_BIN_FACTOR: begin
          bin_factor_nxt = pwdata[FW-1:0];
          cfg_hit        = 1'b1;
        end
        sbb_pkg::REG_PIXEL_COLUMNS: begin
          pixel_columns_nxt = pwdata[CW-1:0];
          cfg_hit           = 1'b1;
        end
        sbb_pkg::REG_PIXEL_ROWS: begin
          pixel_rows_nxt = pwdata[RW-1:0];
          cfg_hit        = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sbb_pkg::REG_BIN_FACTOR:    prdata = sbb_pkg::DATA_W'(bin_factor_r);
      sbb_pkg::REG_PIXEL_COLUMNS: prdata = sbb_pkg::DATA_W'(pixel_columns_r);
      sbb_pkg::REG_PIXEL_ROWS:    prdata = sbb_pkg::DATA_W'(pixel_rows_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_factor_r    <= sbb_pkg::RST_BIN_FACTOR;
      pixel_columns_r <= sbb_pkg::RST_PIXEL_COLUMNS;
      pixel_rows_r    <= sbb_pkg::RST_PIXEL_ROWS;
    end else begin
      bin_factor_r    <= bin_factor_nxt;
      pixel_columns_r <= pixel_columns_nxt;
      pixel_rows_r    <= pixel_rows_nxt;
    end
  end

  // Effective (clamped) geometry
  logic [FW-1:0] f_eff;
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;

  always_comb begin
    if (bin_factor_r == '0) f_eff = FW'(1);
    else if (bin_factor_r > FW'(sbb_pkg::FACTOR_HI)) f_eff = FW'(sbb_pkg::FACTOR_HI);
    else f_eff = bin_factor_r;

    if (pixel_columns_r == '0) cols_eff = CW'(1);
    else if (pixel_columns_r > CW'(sbb_pkg::COLS_HI)) cols_eff = CW'(sbb_pkg::COLS_HI);
    else cols_eff = pixel_columns_r;

    if (pixel_rows_r == '0) rows_eff = RW'(1);
    else if (pixel_rows_r > RW'(sbb_pkg::ROWS_LIMIT)) rows_eff = RW'(sbb_pkg::ROWS_LIMIT);
    else rows_eff = pixel_rows_r;
  end

  // ---------------------------------------------------------------------------
  // Raster counters
  // ---------------------------------------------------------------------------
  logic [SW-1:0]  sub_row_r, sub_row_nxt;
  logic [SW-1:0]  sub_col_r, sub_col_nxt;
  logic [PRW-1:0] pix_row_r, pix_row_nxt;
  logic [PCW-1:0] pix_col_r, pix_col_nxt;

  logic           in_acc;
  logic           restart;
  logic [SW-1:0]  cur_sr, cur_sc;
  logic [PRW-1:0] cur_pr;
  logic [PCW-1:0] cur_pc;
  logic           sc_wrap, sr_wrap, pc_wrap, pr_wrap;
  logic [FW-1:0]  f_m1;
  logic [CW-1:0]  cols_m1;
  logic [RW-1:0]  rows_m1;

  assign in_acc  = in_valid & ~in_stall;
  assign f_m1    = f_eff - FW'(1);
  assign cols_m1 = cols_eff - CW'(1);
  assign rows_m1 = rows_eff - RW'(1);

  // frame_start or stale counters (geometry shrank) restart at pixel (0,0)
  assign restart = in_frame_start
                 | (FW'(sub_row_r) >= f_eff)
                 | (FW'(sub_col_r) >= f_eff)
                 | (CW'(pix_col_r) >= cols_eff)
                 | (RW'(pix_row_r) >= rows_eff);

  assign cur_sr = restart ? '0 : sub_row_r;
  assign cur_sc = restart ? '0 : sub_col_r;
  assign cur_pr = restart ? '0 : pix_row_r;
  assign cur_pc = restart ? '0 : pix_col_r;

  assign sc_wrap = (FW'(cur_sc) == f_m1);
  assign sr_wrap = (FW'(cur_sr) == f_m1);
  assign pc_wrap = (CW'(cur_pc) == cols_m1);
  assign pr_wrap = (RW'(cur_pr) == rows_m1);

  always_comb begin
    sub_row_nxt = sub_row_r;
    sub_col_nxt = sub_col_r;
    pix_row_nxt = pix_row_r;
    pix_col_nxt = pix_col_r;
    priority if (cfg_hit) begin
      sub_row_nxt = '0;
      sub_col_nxt = '0;
      pix_row_nxt = '0;
      pix_col_nxt = '0;
    end else if (in_acc) begin
      sub_col_nxt = sc_wrap ? '0 : cur_sc + SW'(1);
      pix_col_nxt = cur_pc;
      sub_row_nxt = cur_sr;
      pix_row_nxt = cur_pr;
      if (sc_wrap) begin
        pix_col_nxt = pc_wrap ? '0 : cur_pc + PCW'(1);
        if (pc_wrap) begin
          sub_row_nxt = sr_wrap ? '0 : cur_sr + SW'(1);
          if (sr_wrap) begin
            pix_row_nxt = pr_wrap ? '0 : cur_pr + PRW'(1);
          end
        end
      end
    end else begin
      sub_row_nxt = sub_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_row_r <= '0;
      sub_col_r <= '0;
      pix_row_r <= '0;
      pix_col_r <= '0;
    end else begin
      sub_row_r <= sub_row_nxt;
      sub_col_r <= sub_col_nxt;
      pix_row_r <= pix_row_nxt;
      pix_col_r <= pix_col_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Partial-sum line: read at accept, add and write back in the next cycle and never later
  // ---------------------------------------------------------------------------
  rmw_t          s1_r, s1_nxt;
  logic          s1_valid_r;
  logic [DW-1:0] ram_rdata;

  // last write, forwarded when the RAM read missed it
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [DW-1:0] fwd_data_r;

  logic [DW-1:0] old_sum;
  logic [DW:0]   add_sum;
  logic [DW-1:0] new_sum;

  always_comb begin
    s1_nxt.addr  = AW'(cur_pc);
    s1_nxt.flux  = in_flux;
    s1_nxt.first = (cur_sr == '0) && (cur_sc == '0);
    s1_nxt.emit  = sr_wrap & sc_wrap;
    s1_nxt.row   = cur_pr;
    s1_nxt.col   = cur_pc;
    s1_nxt.last  = pr_wrap & pc_wrap;
  end

  sbb_ram #(
    .WIDTH (DW),
    .DEPTH (sbb_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.addr),
    .wdata (new_sum),
    .re    (in_acc),
    .raddr (s1_nxt.addr),
    .rdata (ram_rdata)
  );

  assign old_sum = (fwd_valid_r && (fwd_addr_r == s1_r.addr)) ? fwd_data_r : ram_rdata;
  assign add_sum = (DW+1)'(old_sum) + (DW+1)'(s1_r.flux);

  always_comb begin
    if (s1_r.first) new_sum = DW'(s1_r.flux);
    else if (add_sum[DW]) new_sum = '1;           // saturate
    else new_sum = add_sum[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (s1_valid_r) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_valid_r) begin
      fwd_addr_r <= s1_r.addr;
      fwd_data_r <= new_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus one skid entry
  // ---------------------------------------------------------------------------
  pix_t out_r, skid_r, push_word;
  logic out_valid_r, skid_valid_r;
  logic push, pop;

  assign push = s1_valid_r & s1_r.emit;
  assign pop  = out_valid_r & ~out_stall;

  assign push_word.sum  = new_sum;
  assign push_word.row  = s1_r.row;
  assign push_word.col  = s1_r.col;
  assign push_word.last = s1_r.last;

  // hold off input when a word in flight could find both entries full
  assign in_stall = skid_valid_r | (out_valid_r & out_stall & s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        out_valid_r  <= skid_valid_r | push;
        skid_valid_r <= skid_valid_r & push;
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : push_word;
      if (skid_valid_r && push) begin
        skid_r <= push_word;
      end
    end else if (push) begin
      skid_r <= push_word;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_sum    = out_r.sum;
  assign out_pixel_row    = out_r.row;
  assign out_pixel_column = out_r.col;
  assign out_frame_end    = out_r.last;

`ifndef SYNTH
  // skid entry only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output word");

  // nothing may still be in flight once the skid entry is taken
  a_skid_no_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !s1_valid_r)
    else $error("word in flight while skid entry is full");

  // sub-column counter stays inside the square after every word
  a_sub_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (FW'(sub_col_r) < f_eff))
    else $error("sub-column counter out of range");

  // frame end marks the rightmost pixel column
  a_frame_end_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (CW'(out_r.col) == cols_m1))
    else $error("frame end on a pixel that is not in the last column");
`endif

endmodule

`default_nettype wire
